// ===== hdl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg: shared definitions for the token scanner
// Token kinds, scan modes, the reserved-word table and the result item type.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF   = 16;

  localparam int unsigned KIND_W  = 5;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned NUM_KW  = 5;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;

  localparam logic [KIND_W-1:0] KIND_END     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd1;
  localparam logic [KIND_W-1:0] KIND_STAR    = 5'd2;
  localparam logic [KIND_W-1:0] KIND_QUEST   = 5'd3;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_OR      = 5'd5;
  localparam logic [KIND_W-1:0] KIND_ASSIGN  = 5'd6;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd7;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_LBRACK  = 5'd9;
  localparam logic [KIND_W-1:0] KIND_RBRACK  = 5'd10;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd11;
  localparam logic [KIND_W-1:0] KIND_HASH    = 5'd12;
  localparam logic [KIND_W-1:0] KIND_KW0     = 5'd13;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd18;
  localparam logic [KIND_W-1:0] KIND_WORD    = 5'd19;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] length;
    logic               last;
  } tsp_result_t;

  // Operator kind of a single character, KIND_END when it is no operator.
  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      8'h2A:   k = KIND_STAR;
      8'h3F:   k = KIND_QUEST;
      8'h2B:   k = KIND_PLUS;
      8'h7C:   k = KIND_OR;
      8'h3D:   k = KIND_ASSIGN;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h5B:   k = KIND_LBRACK;
      8'h5D:   k = KIND_RBRACK;
      8'h2C:   k = KIND_COMMA;
      8'h23:   k = KIND_HASH;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  // Length of reserved word k: players, pieces, the ten-letter board word
  // with its size suffix, board, rule.
  function automatic logic [3:0] kw_len(input logic [2:0] k);
    logic [3:0] n;
    case (k)
      3'd0:    n = 4'd7;
      3'd1:    n = 4'd6;
      3'd2:    n = 4'd10;
      3'd3:    n = 4'd5;
      3'd4:    n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Character i of reserved word k.
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] i);
    logic [7:0] ch;
    case ({k, i})
      {3'd0, 4'd0}: ch = "p";
      {3'd0, 4'd1}: ch = "l";
      {3'd0, 4'd2}: ch = "a";
      {3'd0, 4'd3}: ch = "y";
      {3'd0, 4'd4}: ch = "e";
      {3'd0, 4'd5}: ch = "r";
      {3'd0, 4'd6}: ch = "s";
      {3'd1, 4'd0}: ch = "p";
      {3'd1, 4'd1}: ch = "i";
      {3'd1, 4'd2}: ch = "e";
      {3'd1, 4'd3}: ch = "c";
      {3'd1, 4'd4}: ch = "e";
      {3'd1, 4'd5}: ch = "s";
      {3'd2, 4'd0}: ch = "b";
      {3'd2, 4'd1}: ch = "o";
      {3'd2, 4'd2}: ch = "a";
      {3'd2, 4'd3}: ch = "r";
      {3'd2, 4'd4}: ch = "d";
      {3'd2, 4'd5}: ch = "_";
      {3'd2, 4'd6}: ch = "s";
      {3'd2, 4'd7}: ch = "i";
      {3'd2, 4'd8}: ch = "z";
      {3'd2, 4'd9}: ch = "e";
      {3'd3, 4'd0}: ch = "b";
      {3'd3, 4'd1}: ch = "o";
      {3'd3, 4'd2}: ch = "a";
      {3'd3, 4'd3}: ch = "r";
      {3'd3, 4'd4}: ch = "d";
      {3'd4, 4'd0}: ch = "r";
      {3'd4, 4'd1}: ch = "u";
      {3'd4, 4'd2}: ch = "l";
      {3'd4, 4'd3}: ch = "e";
      default:      ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/token_scanner_with_positions.sv =====
// ----------------------------------------------------------------------------
// token_scanner_with_positions: character stream to positioned tokens
// Scans one character per item and queues up to two tokens per item, each
// with kind, start line, start column and lexeme length.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (low bit up)            | side band
//  s_axis   | in        | char_byte[7:0]                       | tuser: end_mark
//  m_axis   | out       | token_kind, start_line, start_column,| tlast: last_of_run
//           |           | lexeme_length, 3 zero bits           |
//
//  One character is accepted per cycle while s_axis_tready is high; its tokens
//  are written into a 4-entry result queue at the accepting edge and leave it
//  one per cycle while m_axis_tready is high. s_axis_tready is high while the
//  queue has two free entries, so an item that ends a number or word can queue
//  both of the tokens that it emits.
//  Reset empties the queue and sets line 1, column 0, between tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module token_scanner_with_positions
  import tsp_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // char_byte[7:0]
  input  wire logic        s_axis_tuser,   // end_mark
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // kind[4:0], line[20:5], column[36:21],
                                           // length[52:37], zero[55:53]
  output logic             m_axis_tlast    // last_of_run
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  // scanner state
  logic [1:0]               mode_q, mode_d;
  logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
  logic [POSITION_BITS-1:0] tline_q, tline_d, tcol_q, tcol_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic [NUM_KW-1:0]        mask_q, mask_d;

  // result queue
  tsp_result_t              q_mem [QDEPTH];
  logic [QAW-1:0]           wr_ptr_q, rd_ptr_q;
  logic [QAW:0]             count_q;

  logic                     accept, pop;
  logic [7:0]               c;
  logic [POSITION_BITS-1:0] line_n, col_n;
  logic [LENGTH_BITS-1:0]   len_inc;
  logic                     is_digit, is_alpha, is_space, is_wordch;
  logic [KIND_W-1:0]        opk, pend_kind;
  logic [NUM_KW-1:0]        mask_cont, mask_first;
  tsp_result_t              pend_res, char_res, res0, res1;
  logic                     emit_pend, emit_char;
  logic [1:0]               n_res;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count_q <= (QAW+1)'(QDEPTH - 2));
  assign c             = s_axis_tdata;

  assign is_digit  = (c >= "0") && (c <= "9");
  assign is_alpha  = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_space  = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  assign is_wordch = is_alpha || is_digit || (c == "-") || (c == "_");
  assign opk       = op_kind(c);

  // advance the position, saturating
  always_comb begin
    line_n = line_q;
    col_n  = col_q;
    if (c == 8'h0A) begin
      if (line_q != '1) line_n = line_q + POSITION_BITS'(1);
      col_n = '0;
    end else if (col_q != '1) begin
      col_n = col_q + POSITION_BITS'(1);
    end
  end

  assign len_inc = (len_q != '1) ? len_q + LENGTH_BITS'(1) : len_q;

  // reserved-word filter, both for a running word and for its first letter
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      mask_cont[k]  = mask_q[k] && (len_q < LENGTH_BITS'(kw_len(3'(k)))) &&
                      (kw_char(3'(k), len_q[3:0]) == c);
      mask_first[k] = (kw_char(3'(k), 4'd0) == c);
    end
  end

  always_comb begin
    pend_kind = (mode_q == MODE_WORD) ? KIND_WORD : KIND_NUMBER;
    if (mode_q == MODE_WORD) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (mask_q[k] && (len_q == LENGTH_BITS'(kw_len(3'(k)))))
          pend_kind = KIND_W'(KIND_KW0 + 5'(k));
      end
    end
  end

  assign pend_res = '{kind: pend_kind, line: FIELD_W'(tline_q), column: FIELD_W'(tcol_q),
                      length: FIELD_W'(len_q), last: 1'b0};

  // decide tokens and the next scanner state
  always_comb begin
    mode_d    = mode_q;
    line_d    = line_q;
    col_d     = col_q;
    tline_d   = tline_q;
    tcol_d    = tcol_q;
    len_d     = len_q;
    mask_d    = mask_q;
    emit_pend = 1'b0;
    emit_char = 1'b0;
    char_res  = '{kind: KIND_UNKNOWN, line: FIELD_W'(line_n), column: FIELD_W'(col_n),
                  length: FIELD_W'(1), last: 1'b0};
    if (s_axis_tuser) begin
      emit_pend       = (mode_q == MODE_NUM) || (mode_q == MODE_WORD);
      emit_char       = 1'b1;
      char_res.kind   = KIND_END;
      char_res.line   = FIELD_W'(line_q);
      char_res.column = FIELD_W'(col_q);
      char_res.length = '0;
      mode_d          = MODE_IDLE;
      len_d           = '0;
      mask_d          = '1;
      line_d          = POSITION_BITS'(1);
      col_d           = '0;
    end else begin
      line_d = line_n;
      col_d  = col_n;
      if ((mode_q == MODE_NUM) && is_digit) begin
        len_d = len_inc;
      end else if ((mode_q == MODE_WORD) && is_wordch) begin
        mask_d = mask_cont;
        len_d  = len_inc;
      end else begin
        // close any pending token, then scan this character on its own
        emit_pend = (mode_q == MODE_NUM) || (mode_q == MODE_WORD);
        mode_d    = MODE_IDLE;
        len_d     = '0;
        mask_d    = '1;
        if (is_space) begin
          emit_char = 1'b0;
        end else if (c == 8'h00) begin
          emit_char       = 1'b1;
          char_res.kind   = KIND_END;
          char_res.length = '0;
        end else if (opk != KIND_END) begin
          emit_char     = 1'b1;
          char_res.kind = opk;
        end else if (is_digit || (c == "-")) begin
          mode_d  = MODE_NUM;
          tline_d = line_n;
          tcol_d  = col_n;
          len_d   = LENGTH_BITS'(1);
        end else if (is_alpha) begin
          mode_d  = MODE_WORD;
          tline_d = line_n;
          tcol_d  = col_n;
          len_d   = LENGTH_BITS'(1);
          mask_d  = mask_first;
        end else begin
          emit_char = 1'b1;
        end
      end
    end
  end

  always_comb begin
    res0  = emit_pend ? pend_res : char_res;
    res1  = char_res;
    n_res = 2'(emit_pend) + 2'(emit_char);
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= POSITION_BITS'(1);
      col_q   <= '0;
      tline_q <= POSITION_BITS'(1);
      tcol_q  <= '0;
      len_q   <= '0;
      mask_q  <= '1;
    end else if (accept) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      len_q   <= len_d;
      mask_q  <= mask_d;
    end
  end

  // queue payload needs no reset
  always_ff @(posedge clk_i) begin
    if (accept && (n_res != 2'd0)) q_mem[wr_ptr_q] <= res0;
    if (accept && (n_res == 2'd2)) q_mem[wr_ptr_q + QAW'(1)] <= res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (accept) wr_ptr_q <= wr_ptr_q + QAW'(n_res);
      if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
      count_q <= count_q + (QAW+1)'(accept ? n_res : 2'd0) - (QAW+1)'(pop);
    end
  end

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {3'b000, q_mem[rd_ptr_q].length, q_mem[rd_ptr_q].column,
                          q_mem[rd_ptr_q].line, q_mem[rd_ptr_q].kind};
  assign m_axis_tlast  = q_mem[rd_ptr_q].last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QAW+1)'(QDEPTH))
    else $error("result queue overflow");

  a_no_push_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && !s_axis_tready) |=> (count_q <= $past(count_q)))
    else $error("queue grew while input was stalled");

  a_end_resets_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser) |=>
      ((line_q == POSITION_BITS'(1)) && (col_q == '0) && (mode_q == MODE_IDLE)))
    else $error("end mark did not reset the position");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stream test of the token scanner
// Feeds characters and end marks through the input stream with random gaps,
// predicts each token (kind, start line, start column, length, last flag) in
// a scanner of its own, and compares every output item against the oldest
// predicted token. Covers operators, numbers, words, keywords, NUL, high
// bytes and end marks.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tsp_pkg::*;

  localparam int unsigned POS_MAX     = 16'hFFFF;
  localparam int unsigned LEN_MAX     = 16'hFFFF;
  localparam int          STALL_LIMIT = 1000;
  localparam int          RAND_ITEMS  = 1215;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct {
    logic [7:0] ch;
    logic       endm;
    bit         drain;   // hold until every predicted token has come out
    bit         burst;   // no gap after this item
  } char_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;  // char_byte[7:0]
  logic        s_axis_tuser = 1'b0;   // end_mark
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;          // kind, line, column, length, zero[55:53]
  logic        m_axis_tlast;          // last_of_run

  token_scanner_with_positions i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // scanner state mirrored for prediction
  logic [1:0]  scan_mode = MODE_IDLE;
  int unsigned cur_line = 1;
  int unsigned cur_col = 0;
  int unsigned tok_line = 1;
  int unsigned tok_col = 0;
  int unsigned run_len = 0;
  logic [4:0]  kw_alive = 5'h1F;
  string       kw_words [5] = '{"players", "pieces", {"board", "_size"}, "board", "rule"};

  char_item_t  char_feed [$];
  tsp_result_t pending_tokens [$];
  tsp_result_t want;
  char_item_t  next_char;
  logic        in_taken = 1'b0;
  int          fail_count = 0;
  int          send_gap = 0;
  bit          send_idle = 1'b0;
  int          recv_stall = 0;
  bit          recv_idle = 1'b0;
  int          quiet_cycles = 0;

  function automatic int pick_gap(bit idling);
    int r;
    r = $urandom_range(0, 99);
    if (!idling || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [4:0] operator_kind(logic [7:0] c);
    case (c)
      "*":     return KIND_STAR;
      "?":     return KIND_QUEST;
      "+":     return KIND_PLUS;
      "|":     return KIND_OR;
      "=":     return KIND_ASSIGN;
      "(":     return KIND_LPAREN;
      ")":     return KIND_RPAREN;
      "[":     return KIND_LBRACK;
      "]":     return KIND_RBRACK;
      ",":     return KIND_COMMA;
      "#":     return KIND_HASH;
      default: return KIND_END;
    endcase
  endfunction

  function automatic void emit_token(logic [4:0] kind, int unsigned ln, int unsigned col,
                                     int unsigned len);
    tsp_result_t t;
    t.kind   = kind;
    t.line   = ln[15:0];
    t.column = col[15:0];
    t.length = len[15:0];
    t.last   = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  // drop keywords whose next letter differs from c
  function automatic void match_keywords(logic [7:0] c);
    for (int k = 0; k < 5; k++)
      if (!(run_len < kw_words[k].len() && kw_words[k][run_len] == c))
        kw_alive[k] = 1'b0;
  endfunction

  function automatic void grow_token();
    if (run_len < LEN_MAX) run_len++;
  endfunction

  function automatic void begin_token(logic [1:0] mode);
    scan_mode = mode;
    tok_line  = cur_line;
    tok_col   = cur_col;
    run_len   = 0;
    kw_alive  = 5'h1F;
  endfunction

  function automatic void close_token();
    logic [4:0] kind;
    kind = KIND_NUMBER;
    if (scan_mode == MODE_WORD) begin
      kind = KIND_WORD;
      for (int k = 0; k < 5; k++)
        if (kw_alive[k] && run_len == kw_words[k].len()) kind = KIND_KW0 + 5'(k);
    end
    if (scan_mode == MODE_NUM || scan_mode == MODE_WORD)
      emit_token(kind, tok_line, tok_col, run_len);
    scan_mode = MODE_IDLE;
    run_len   = 0;
    kw_alive  = 5'h1F;
  endfunction

  function automatic void scan_char(logic [7:0] c, logic endm);
    int         n_before;
    bit         absorbed;
    logic [4:0] op;
    n_before = pending_tokens.size();
    absorbed = 1'b0;
    if (endm) begin
      close_token();
      emit_token(KIND_END, cur_line, cur_col, 0);
      cur_line = 1;
      cur_col  = 0;
    end else begin
      if (c == CH_NL) begin
        if (cur_line < POS_MAX) cur_line++;
        cur_col = 0;
      end else if (cur_col < POS_MAX) begin
        cur_col++;
      end
      if (scan_mode == MODE_NUM && is_digit(c)) begin
        grow_token();
        absorbed = 1'b1;
      end else if (scan_mode == MODE_WORD &&
                   (is_alpha(c) || is_digit(c) || c == CH_MINUS || c == CH_UNDER)) begin
        match_keywords(c);
        grow_token();
        absorbed = 1'b1;
      end else begin
        close_token();
      end
      if (!absorbed) begin
        op = operator_kind(c);
        if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
          // whitespace: skip
        end else if (c == CH_NUL) begin
          emit_token(KIND_END, cur_line, cur_col, 0);
        end else if (op != KIND_END) begin
          emit_token(op, cur_line, cur_col, 1);
        end else if (is_digit(c) || c == CH_MINUS) begin
          begin_token(MODE_NUM);
          grow_token();
        end else if (is_alpha(c)) begin
          begin_token(MODE_WORD);
          match_keywords(c);
          grow_token();
        end else begin
          emit_token(KIND_UNKNOWN, cur_line, cur_col, 1);
        end
      end
    end
    if (pending_tokens.size() > n_before)
      pending_tokens[pending_tokens.size()-1].last = 1'b1;
  endfunction

  task automatic queue_char(logic [7:0] c, logic endm = 1'b0, bit drain = 1'b0,
                            bit burst = 1'b0);
    char_item_t it;
    it.ch    = c;
    it.endm  = endm;
    it.drain = drain;
    it.burst = burst;
    char_feed.push_back(it);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  // sender: advance on acceptance, then idle or load the next item
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (char_feed.size() != 0 &&
                   !(char_feed[0].drain && pending_tokens.size() != 0)) begin
        next_char = char_feed.pop_front();
        if ($urandom_range(0, 63) == 0) send_idle = !send_idle;
        send_gap = next_char.burst ? 0 : pick_gap(send_idle);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_char.ch;
        s_axis_tuser  <= next_char.endm;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) recv_idle = !recv_idle;
        recv_stall = pick_gap(recv_idle);
        m_axis_tready <= (recv_stall == 0);
      end
    end
  end

  // predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) scan_char(s_axis_tdata, s_axis_tuser);
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_tokens.size() == 0) begin
          $error("token out with none predicted: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (m_axis_tdata[4:0] != want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tdata[4:0]);
            fail_count++;
          end
          if (m_axis_tdata[20:5] != want.line) begin
            $error("start_line: expected %0d, got %0d", want.line, m_axis_tdata[20:5]);
            fail_count++;
          end
          if (m_axis_tdata[36:21] != want.column) begin
            $error("start_column: expected %0d, got %0d", want.column,
                   m_axis_tdata[36:21]);
            fail_count++;
          end
          if (m_axis_tdata[52:37] != want.length) begin
            $error("lexeme_length: expected %0d, got %0d", want.length,
                   m_axis_tdata[52:37]);
            fail_count++;
          end
          if (m_axis_tdata[55:53] != 3'b000) begin
            $error("tdata pad: expected 0, got %0d", m_axis_tdata[55:53]);
            fail_count++;
          end
          if (m_axis_tlast != want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] ws_set [6];
    string      op_chars;
    string      odd_chars;
    string      word_chars;
    int         rand_items;
    int         pick;
    int         n;
    int         k;

    ws_set     = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    op_chars   = "*?+|=()[],#";
    odd_chars  = "@!$%&.;:<>{}~^`'";
    word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_";

    // directed: every operator, number into word, word into NUL, high bytes,
    // whitespace, end mark on a pending word, repeated end marks
    queue_text(op_chars);
    queue_text("-9a_Z");
    queue_char(CH_NUL);
    queue_char(8'hFF);
    queue_char(8'h80);
    queue_char(8'h0B);
    queue_char(8'h0C);
    queue_char(8'h0D);
    queue_char(8'h09);
    queue_char(CH_NL);
    queue_text("5)x");
    queue_char(8'h00, 1'b1);
    queue_char(8'hA5, 1'b1, 1'b1);

    // operators back to back, a number closed by an unknown, then an end mark
    queue_text("++");
    queue_text("7;");
    queue_char(8'h5A, 1'b1, 1'b1);

    // random: mostly well-formed token streams, some noise
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      n = char_feed.size();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        k = $urandom_range(0, 4);
        pick = $urandom_range(0, 99);
        for (int i = 0; i < (pick < 15 ? $urandom_range(1, kw_words[k].len() - 1)
                                         : kw_words[k].len()); i++)
          queue_char(kw_words[k][i]);
        if (pick >= 15 && pick < 40)
          repeat ($urandom_range(1, 3))
            queue_char(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end else if (pick < 45) begin
        queue_char(word_chars[$urandom_range(0, 51)]);
        repeat ($urandom_range(0, 8))
          queue_char(word_chars[$urandom_range(0, word_chars.len() - 1)]);
      end else if (pick < 60) begin
        if ($urandom_range(0, 2) == 0) queue_char(CH_MINUS);
        repeat ($urandom_range(1, 5)) queue_char(8'h30 + 8'($urandom_range(0, 9)));
      end else if (pick < 75) begin
        queue_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
      end else if (pick < 82) begin
        if ($urandom_range(0, 1) == 0) queue_char(8'($urandom_range(128, 255)));
        else queue_char(odd_chars[$urandom_range(0, odd_chars.len() - 1)]);
      end else if (pick < 85) begin
        queue_char(CH_NUL);
      end else if (pick < 89) begin
        queue_char(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        queue_char(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 60) queue_char(ws_set[$urandom_range(0, 5)]);
      if ($urandom_range(0, 149) == 0) char_feed[char_feed.size()-1].drain = 1'b1;
      rand_items += char_feed.size() - n;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (char_feed.size() != 0 || s_axis_tvalid || pending_tokens.size() != 0);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== token_scanner_with_positions.f =====
hdl/tsp_pkg.sv
hdl/token_scanner_with_positions.sv
sim/tb_top.sv
